[design/jdam_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers of the joystick dead-band axis mapper.
package jdam_pkg;

  localparam int SAMPLE_BITS_DEF = 10;

  localparam int DZ_W       = 9;
  localparam int FS_W       = 15;
  localparam int RES_W      = 16;
  localparam int QUO_W      = 16;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
  localparam int PIPE_STAGES = 2 + DIV_STAGES;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [DZ_W-1:0] STICK_DZ_RST     = 9'd50;
  localparam logic [DZ_W-1:0] THR_DZ_RST       = 9'd25;
  localparam logic [FS_W-1:0] NORMAL_FS_RST    = 15'd32767;
  localparam logic [FS_W-1:0] PRECISION_FS_RST = 15'd8192;
  localparam logic [FS_W-1:0] THROTTLE_FULL    = 15'd32767;

  // Stick lanes; the throttle lane follows them.
  localparam int NUM_STICK  = 7;
  localparam int LANE_STEER = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_PITCH = 2;
  localparam int LANE_ROLL  = 3;
  localparam int LANE_MX    = 4;
  localparam int LANE_MY    = 5;
  localparam int LANE_MZ    = 6;

  // Lanes that map mirrored: steer and the three translation axes.
  localparam logic [NUM_STICK-1:0] STICK_MIRROR = 7'b111_0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_DZ     = 2'd0,
    CFG_THR_DZ       = 2'd1,
    CFG_NORMAL_FS    = 2'd2,
    CFG_PRECISION_FS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_FULL = 2'd1,
    MODE_DIV  = 2'd2
  } lane_mode_e;

  // How a lane forms its result: zero, full scale, or quotient; neg puts it below zero.
  typedef struct packed {
    lane_mode_e      mode;
    logic            neg;
    logic [FS_W-1:0] fs;
  } lane_ctl_t;

  typedef struct packed {
    logic [DZ_W-1:0] stick_dz;
    logic [DZ_W-1:0] thr_dz;
    logic [FS_W-1:0] fs_normal;
    logic [FS_W-1:0] fs_precision;
  } cfg_t;

  // Operand width: holds every sample span and twice the throttle margin.
  function automatic int opnd_width(int sb);
    return (sb > DZ_W + 1) ? sb : DZ_W + 1;
  endfunction

endpackage

[design/jdam_if.sv]
`timescale 1ns / 1ps
// Item channels of the joystick dead-band axis mapper: sample set in, control values out.
interface jdam_in_if import jdam_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] throttle_raw;
  logic [SAMPLE_BITS-1:0] orient_x;
  logic [SAMPLE_BITS-1:0] orient_y;
  logic [SAMPLE_BITS-1:0] orient_z;
  logic [SAMPLE_BITS-1:0] move_x_raw;
  logic [SAMPLE_BITS-1:0] move_y_raw;
  logic [SAMPLE_BITS-1:0] move_z_raw;
  logic                   precision_on;
  logic                   rocket_on;

  modport source (
    output valid, throttle_raw, orient_x, orient_y, orient_z,
    output move_x_raw, move_y_raw, move_z_raw, precision_on, rocket_on,
    input  ready
  );
  modport sink (
    input  valid, throttle_raw, orient_x, orient_y, orient_z,
    input  move_x_raw, move_y_raw, move_z_raw, precision_on, rocket_on,
    output ready
  );
endinterface

interface jdam_out_if import jdam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FS_W-1:0]         throttle_out;
  logic signed [RES_W-1:0] steer;
  logic signed [RES_W-1:0] yaw;
  logic signed [RES_W-1:0] pitch;
  logic signed [RES_W-1:0] roll;
  logic signed [RES_W-1:0] move_x;
  logic signed [RES_W-1:0] move_y;
  logic signed [RES_W-1:0] move_z;

  modport source (
    output valid, throttle_out, steer, yaw, pitch, roll, move_x, move_y, move_z,
    input  ready
  );
  modport sink (
    input  valid, throttle_out, steer, yaw, pitch, roll, move_x, move_y, move_z,
    output ready
  );
endinterface

[design/jdam_div_stage.sv]
`timescale 1ns / 1ps
// One registered slice of the restoring divider: STEPS quotient bits per stage.
module jdam_div_stage import jdam_pkg::*; #(
  parameter int DW    = 10,
  parameter int STEPS = DIV_STEPS
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DW-1:0]   rem_i,
  input  logic [QUO_W-1:0] rq_i,
  input  logic [DW-1:0]   den_i,
  input  lane_ctl_t       ctl_i,
  output logic [DW-1:0]   rem_o,
  output logic [QUO_W-1:0] rq_o,
  output logic [DW-1:0]   den_o,
  output lane_ctl_t       ctl_o
);

  logic [DW:0]      trial;
  logic [DW-1:0]    rem_d;
  logic [QUO_W-1:0] rq_d;

  // Shift dividend bits out of the top of rq while quotient bits enter at the bottom.
  always_comb begin
    rem_d = rem_i;
    rq_d  = rq_i;
    trial = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_d, rq_d[QUO_W-1]};
      rq_d  = {rq_d[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        trial   = trial - {1'b0, den_i};
        rq_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      rq_o  <= rq_d;
      den_o <= den_i;
      ctl_o <= ctl_i;
    end
  end

endmodule

[design/jdam_stick_prep.sv]
`timescale 1ns / 1ps
// Dead-band test of one stick sample and the operands of its linear map.
module jdam_stick_prep import jdam_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  input  logic [DZ_W-1:0]                    dz_i,
  input  logic [FS_W-1:0]                    fs_i,
  input  logic                               mirror_i,
  output logic [opnd_width(SAMPLE_BITS)-1:0] num_o,
  output logic [opnd_width(SAMPLE_BITS)-1:0] den_o,
  output lane_ctl_t                          ctl_o
);

  localparam int DW = opnd_width(SAMPLE_BITS);
  localparam int SW = DW + 2;
  localparam logic signed [SW-1:0] CTR    = SW'(2 ** (SAMPLE_BITS - 1));
  localparam logic signed [SW-1:0] TOP    = SW'(2 ** SAMPLE_BITS - 1);
  localparam logic signed [SW-1:0] ZERO_S = '0;

  logic signed [SW-1:0] v;
  logic signed [SW-1:0] d;
  logic signed [SW-1:0] hi_start;
  logic signed [SW-1:0] lo_end;
  logic signed [SW-1:0] hi_den;

  assign v        = $signed(SW'(sample_i));
  assign d        = $signed(SW'(dz_i));
  assign hi_start = CTR + d;
  assign lo_end   = CTR - d;
  assign hi_den   = TOP - hi_start;

  always_comb begin
    num_o      = '0;
    den_o      = '0;
    ctl_o.mode = MODE_ZERO;
    ctl_o.neg  = 1'b0;
    ctl_o.fs   = fs_i;
    if (v >= hi_start) begin
      ctl_o.neg = mirror_i;
      if (hi_den <= ZERO_S) begin
        ctl_o.mode = MODE_FULL;
      end else begin
        ctl_o.mode = MODE_DIV;
        den_o      = DW'(hi_den);
        num_o      = mirror_i ? DW'(TOP - v) : DW'(v - hi_start);
      end
    end else if (v <= lo_end) begin
      ctl_o.neg = !mirror_i;
      if (lo_end <= ZERO_S) begin
        ctl_o.mode = MODE_FULL;
      end else begin
        ctl_o.mode = MODE_DIV;
        den_o      = DW'(lo_end);
        num_o      = mirror_i ? DW'(lo_end - v) : DW'(v);
      end
    end
  end

endmodule

[design/jdam_lane.sv]
`timescale 1ns / 1ps
// One mapping lane: operand register, scale multiply, pipelined divide, sign fix-up.
module jdam_lane import jdam_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic [PIPE_STAGES-1:0]             en_i,
  input  logic [opnd_width(SAMPLE_BITS)-1:0] num_i,
  input  logic [opnd_width(SAMPLE_BITS)-1:0] den_i,
  input  lane_ctl_t                          ctl_i,
  output logic [RES_W-1:0]                   res_o
);

  localparam int DW = opnd_width(SAMPLE_BITS);
  localparam int PW = DW + FS_W;

  logic [DW-1:0] num_q;
  logic [DW-1:0] den0_q;
  lane_ctl_t     ctl0_q;
  logic [PW-1:0] prod_q;
  logic [DW-1:0] den1_q;
  lane_ctl_t     ctl1_q;

  logic [DW-1:0]    rem_s [DIV_STAGES+1];
  logic [QUO_W-1:0] rq_s  [DIV_STAGES+1];
  logic [DW-1:0]    den_s [DIV_STAGES+1];
  lane_ctl_t        ctl_s [DIV_STAGES+1];

  logic [FS_W-1:0]  quo;
  lane_ctl_t        ctl_last;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_q  <= num_i;
      den0_q <= den_i;
      ctl0_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= PW'(num_q) * PW'(ctl0_q.fs);
      den1_q <= den0_q;
      ctl1_q <= ctl0_q;
    end
  end

  // Numerator never exceeds the span, so the quotient fits the full scale
  // and the top bits of the product already sit below the divisor.
  assign rem_s[0] = {1'b0, prod_q[PW-1:QUO_W]};
  assign rq_s[0]  = prod_q[QUO_W-1:0];
  assign den_s[0] = den1_q;
  assign ctl_s[0] = ctl1_q;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    jdam_div_stage #(
      .DW    (DW),
      .STEPS (DIV_STEPS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_i[2+k]),
      .rem_i (rem_s[k]),
      .rq_i  (rq_s[k]),
      .den_i (den_s[k]),
      .ctl_i (ctl_s[k]),
      .rem_o (rem_s[k+1]),
      .rq_o  (rq_s[k+1]),
      .den_o (den_s[k+1]),
      .ctl_o (ctl_s[k+1])
    );
  end

  assign quo      = rq_s[DIV_STAGES][FS_W-1:0];
  assign ctl_last = ctl_s[DIV_STAGES];

  always_comb begin
    case (ctl_last.mode)
      MODE_DIV: begin
        res_o = ctl_last.neg ? ({1'b0, quo} - {1'b0, ctl_last.fs}) : {1'b0, quo};
      end
      MODE_FULL: begin
        res_o = ctl_last.neg ? (RES_W'(0) - {1'b0, ctl_last.fs}) : {1'b0, ctl_last.fs};
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

[design/jdam_merge.sv]
`timescale 1ns / 1ps
// Output register: gathers the lane results into one result item.
module jdam_merge import jdam_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pipe_vld_i,
  input  logic [NUM_STICK:0][RES_W-1:0]   lane_res_i,
  output logic                            take_o,
  jdam_out_if.source                      out_o
);

  logic                              out_vld_q;
  logic [FS_W-1:0]                   thr_q;
  logic [NUM_STICK-1:0][RES_W-1:0]   stick_q;

  assign take_o = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take_o) begin
      out_vld_q <= pipe_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && pipe_vld_i) begin
      thr_q   <= lane_res_i[NUM_STICK][FS_W-1:0];
      stick_q <= lane_res_i[NUM_STICK-1:0];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.throttle_out = thr_q;
  assign out_o.steer        = $signed(stick_q[LANE_STEER]);
  assign out_o.yaw          = $signed(stick_q[LANE_YAW]);
  assign out_o.pitch        = $signed(stick_q[LANE_PITCH]);
  assign out_o.roll         = $signed(stick_q[LANE_ROLL]);
  assign out_o.move_x       = $signed(stick_q[LANE_MX]);
  assign out_o.move_y       = $signed(stick_q[LANE_MY]);
  assign out_o.move_z       = $signed(stick_q[LANE_MZ]);

endmodule

[design/joystick_deadzone_axis_mapper.sv]
`timescale 1ns / 1ps
// Joystick dead-band axis mapper: eight parallel lanes, one per control value.
// Steps: the operand register loads at the accept edge, then multiply, four divide stages of four
// quotient bits each, output register. One item per cycle while the output is taken; stages with
// no item collapse, so input stays open while a finished result waits and a stage is still empty.
// Reset: config registers take their defaults, pipe empties.
module joystick_deadzone_axis_mapper import jdam_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  jdam_in_if.sink               in_i,
  jdam_out_if.source            out_o
);

  localparam int DW = opnd_width(SAMPLE_BITS);
  localparam int SW = DW + 2;
  localparam logic signed [SW-1:0] TOP    = SW'(2 ** SAMPLE_BITS - 1);
  localparam logic signed [SW-1:0] ZERO_S = '0;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_dz     <= STICK_DZ_RST;
      cfg_q.thr_dz       <= THR_DZ_RST;
      cfg_q.fs_normal    <= NORMAL_FS_RST;
      cfg_q.fs_precision <= PRECISION_FS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STICK_DZ:     cfg_q.stick_dz     <= cfg_data_i[DZ_W-1:0];
        CFG_THR_DZ:       cfg_q.thr_dz       <= cfg_data_i[DZ_W-1:0];
        CFG_NORMAL_FS:    cfg_q.fs_normal    <= cfg_data_i[FS_W-1:0];
        CFG_PRECISION_FS: cfg_q.fs_precision <= cfg_data_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] en;
  logic                   out_take;

  always_comb begin
    en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_take;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lane sources. Rocket mode drives yaw and steer from orient_x and roll from
  // orient_z; plane mode swaps the two. Pitch always follows orient_y.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]                yaw_src;
  logic [SAMPLE_BITS-1:0]                roll_src;
  logic [NUM_STICK-1:0][SAMPLE_BITS-1:0] stick_smp;
  logic [FS_W-1:0]                       fs_sel;

  assign yaw_src  = in_i.rocket_on ? in_i.orient_x : in_i.orient_z;
  assign roll_src = in_i.rocket_on ? in_i.orient_z : in_i.orient_x;
  assign fs_sel   = in_i.precision_on ? cfg_q.fs_precision : cfg_q.fs_normal;

  assign stick_smp[LANE_STEER] = yaw_src;
  assign stick_smp[LANE_YAW]   = yaw_src;
  assign stick_smp[LANE_PITCH] = in_i.orient_y;
  assign stick_smp[LANE_ROLL]  = roll_src;
  assign stick_smp[LANE_MX]    = in_i.move_x_raw;
  assign stick_smp[LANE_MY]    = in_i.move_y_raw;
  assign stick_smp[LANE_MZ]    = in_i.move_z_raw;

  logic [NUM_STICK:0][DW-1:0] lane_num;
  logic [NUM_STICK:0][DW-1:0] lane_den;
  lane_ctl_t                  lane_ctl [NUM_STICK+1];
  logic [NUM_STICK:0][RES_W-1:0] lane_res;

  for (genvar i = 0; i < NUM_STICK; i++) begin : g_prep
    jdam_stick_prep #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
      .sample_i (stick_smp[i]),
      .dz_i     (cfg_q.stick_dz),
      .fs_i     (fs_sel),
      .mirror_i (STICK_MIRROR[i]),
      .num_o    (lane_num[i]),
      .den_o    (lane_den[i]),
      .ctl_o    (lane_ctl[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Throttle setup: inverted travel over [TD, TOP-TD]. A span of zero, or a
  // numerator at least as large as the span, saturates to full; a zero numerator
  // or opposite signs give zero, and like signs divide the magnitudes.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] thr_t;
  logic signed [SW-1:0] thr_td;
  logic signed [SW-1:0] thr_num_s;
  logic signed [SW-1:0] thr_den_s;
  logic [SW-1:0]        thr_num_a;
  logic [SW-1:0]        thr_den_a;

  assign thr_t     = $signed(SW'(in_i.throttle_raw));
  assign thr_td    = $signed(SW'(cfg_q.thr_dz));
  assign thr_num_s = TOP - thr_td - thr_t;
  assign thr_den_s = TOP - (thr_td <<< 1);
  assign thr_num_a = thr_num_s[SW-1] ? SW'(-thr_num_s) : SW'(thr_num_s);
  assign thr_den_a = thr_den_s[SW-1] ? SW'(-thr_den_s) : SW'(thr_den_s);

  always_comb begin
    lane_num[NUM_STICK]      = '0;
    lane_den[NUM_STICK]      = '0;
    lane_ctl[NUM_STICK].mode = MODE_ZERO;
    lane_ctl[NUM_STICK].neg  = 1'b0;
    lane_ctl[NUM_STICK].fs   = THROTTLE_FULL;
    if (thr_den_s == ZERO_S) begin
      lane_ctl[NUM_STICK].mode = MODE_FULL;
    end else if (thr_num_s == ZERO_S || (thr_num_s[SW-1] != thr_den_s[SW-1])) begin
      lane_ctl[NUM_STICK].mode = MODE_ZERO;
    end else if (thr_num_a >= thr_den_a) begin
      lane_ctl[NUM_STICK].mode = MODE_FULL;
    end else begin
      lane_ctl[NUM_STICK].mode = MODE_DIV;
      lane_num[NUM_STICK]      = thr_num_a[DW-1:0];
      lane_den[NUM_STICK]      = thr_den_a[DW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes: seven stick lanes plus the throttle lane, all in lockstep.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i <= NUM_STICK; i++) begin : g_lane
    jdam_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (lane_num[i]),
      .den_i (lane_den[i]),
      .ctl_i (lane_ctl[i]),
      .res_o (lane_res[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge into the output register
  // ---------------------------------------------------------------------------
  jdam_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pipe_vld_i (vld_q[PIPE_STAGES-1]),
    .lane_res_i (lane_res),
    .take_o     (out_take),
    .out_o      (out_o)
  );

endmodule

[design/jdam_chk.sv]
`timescale 1ns / 1ps
// Port-level checker of the joystick dead-band axis mapper, bound to the top level.
module jdam_chk import jdam_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [FS_W-1:0]         throttle_out,
  input logic signed [RES_W-1:0] steer,
  input logic signed [RES_W-1:0] yaw,
  input logic signed [RES_W-1:0] pitch,
  input logic signed [RES_W-1:0] roll,
  input logic signed [RES_W-1:0] move_x,
  input logic signed [RES_W-1:0] move_y,
  input logic signed [RES_W-1:0] move_z
);

  localparam int DEPTH = PIPE_STAGES + 1;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] cnt_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable({throttle_out, steer, yaw, pitch, roll, move_x, move_y, move_z}))
    else $error("result item changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> cnt_q != '0)
    else $error("result item without an accepted input item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_steer_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (yaw != '0) |-> (steer == '0) || (steer[RES_W-1] != yaw[RES_W-1]))
    else $error("steer not mirrored against yaw");

endmodule

bind joystick_deadzone_axis_mapper jdam_chk u_jdam_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .throttle_out (out_o.throttle_out),
  .steer        (out_o.steer),
  .yaw          (out_o.yaw),
  .pitch        (out_o.pitch),
  .roll         (out_o.roll),
  .move_x       (out_o.move_x),
  .move_y       (out_o.move_y),
  .move_z       (out_o.move_z)
);

[bench/tb_joystick_deadzone_axis_mapper.sv]
`timescale 1ns / 1ps
// Self-checking bench: random sample sets through the axis mapper, checked by a local predictor.
module tb_joystick_deadzone_axis_mapper import jdam_pkg::*; ();

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int CENTER       = 1 << (SB - 1);
  localparam int TOP          = (1 << SB) - 1;
  localparam int THR_MAX      = 32767;
  localparam int FS_MAX       = 32767;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  // One sample set as the sender drives it.
  typedef struct packed {
    logic [SB-1:0] throttle_raw;
    logic [SB-1:0] orient_x;
    logic [SB-1:0] orient_y;
    logic [SB-1:0] orient_z;
    logic [SB-1:0] move_x_raw;
    logic [SB-1:0] move_y_raw;
    logic [SB-1:0] move_z_raw;
    logic          precision_on;
    logic          rocket_on;
  } sample_set_t;

  // The eight control values that one sample set must produce.
  typedef struct packed {
    logic [FS_W-1:0]         throttle_out;
    logic signed [RES_W-1:0] steer;
    logic signed [RES_W-1:0] yaw;
    logic signed [RES_W-1:0] pitch;
    logic signed [RES_W-1:0] roll;
    logic signed [RES_W-1:0] move_x;
    logic signed [RES_W-1:0] move_y;
    logic signed [RES_W-1:0] move_z;
  } controls_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  jdam_in_if #(.SAMPLE_BITS(SB)) in_if ();
  jdam_out_if                    out_if ();

  joystick_deadzone_axis_mapper #(.SAMPLE_BITS(SB)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Local copy of the configuration registers, updated as each write lands.
  int stick_dz_cur     = int'(STICK_DZ_RST);
  int thr_dz_cur       = int'(THR_DZ_RST);
  int fs_normal_cur    = int'(NORMAL_FS_RST);
  int fs_precision_cur = int'(PRECISION_FS_RST);

  sample_set_t pending_sets_q[$];
  controls_t   expected_controls_q[$];
  sample_set_t taken_set;
  controls_t   want;

  int items_issued  = 0;
  int items_taken   = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int src_gap       = 0;
  int snk_gap       = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int clip(int x, int lo, int hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Direct stick map: high sample gives a positive value. Division truncates toward zero.
  function automatic logic signed [RES_W-1:0] stick_direct(int v, int d, int fs);
    int hi_start;
    int lo_end;
    int den;
    int r;
    hi_start = CENTER + d;
    lo_end   = CENTER - d;
    if (v >= hi_start) begin
      den = TOP - hi_start;
      // Dead band reaching the top of travel: any high sample is full deflection.
      r = (den <= 0) ? fs : (v - hi_start) * fs / den;
      r = clip(r, 0, fs);
    end else if (v <= lo_end) begin
      r = (lo_end <= 0) ? -fs : v * fs / lo_end - fs;
      r = clip(r, -fs, 0);
    end else begin
      r = 0;
    end
    return r[RES_W-1:0];
  endfunction

  // Mirrored stick map: high sample gives a negative value; not an exact negation.
  function automatic logic signed [RES_W-1:0] stick_mirror(int v, int d, int fs);
    int hi_start;
    int lo_end;
    int den;
    int r;
    hi_start = CENTER + d;
    lo_end   = CENTER - d;
    if (v >= hi_start) begin
      den = TOP - hi_start;
      r = (den <= 0) ? -fs : (TOP - v) * fs / den - fs;
      r = clip(r, -fs, 0);
    end else if (v <= lo_end) begin
      r = (lo_end <= 0) ? fs : (lo_end - v) * fs / lo_end;
      r = clip(r, 0, fs);
    end else begin
      r = 0;
    end
    return r[RES_W-1:0];
  endfunction

  // Inverted throttle over [td, TOP-td]; a negative span divides signed, then clamps.
  function automatic logic [FS_W-1:0] throttle_map(int t, int td);
    int den;
    int r;
    den = TOP - 2 * td;
    r = (den == 0) ? THR_MAX : (TOP - td - t) * THR_MAX / den;
    r = clip(r, 0, THR_MAX);
    return r[FS_W-1:0];
  endfunction

  function automatic controls_t predict_controls(sample_set_t s);
    controls_t c;
    int fs;
    int yaw_src;
    int roll_src;
    fs       = s.precision_on ? fs_precision_cur : fs_normal_cur;
    // Rocket mode: x drives yaw and z drives roll; plane mode swaps them.
    yaw_src  = s.rocket_on ? int'(s.orient_x) : int'(s.orient_z);
    roll_src = s.rocket_on ? int'(s.orient_z) : int'(s.orient_x);
    c.throttle_out = throttle_map(int'(s.throttle_raw), thr_dz_cur);
    c.steer  = stick_mirror(yaw_src, stick_dz_cur, fs);
    c.yaw    = stick_direct(yaw_src, stick_dz_cur, fs);
    c.pitch  = stick_direct(int'(s.orient_y), stick_dz_cur, fs);
    c.roll   = stick_direct(roll_src, stick_dz_cur, fs);
    c.move_x = stick_mirror(int'(s.move_x_raw), stick_dz_cur, fs);
    c.move_y = stick_mirror(int'(s.move_y_raw), stick_dz_cur, fs);
    c.move_z = stick_mirror(int'(s.move_z_raw), stick_dz_cur, fs);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Sample biased toward the band edges lo and hi, the travel ends and the band inside.
  function automatic logic [SB-1:0] pick_sample(int lo, int hi);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, TOP);
      4, 5:       v = hi + $urandom_range(0, 6) - 3;
      6, 7:       v = lo + $urandom_range(0, 6) - 3;
      8:          v = $urandom_range(0, 1) ? $urandom_range(0, 1) : TOP - $urandom_range(0, 1);
      default:    v = (hi > lo) ? $urandom_range(lo, hi) : lo;
    endcase
    v = clip(v, 0, TOP);
    return v[SB-1:0];
  endfunction

  function automatic sample_set_t rand_set();
    sample_set_t s;
    int lo;
    int hi;
    lo = CENTER - stick_dz_cur;
    hi = CENTER + stick_dz_cur;
    s.throttle_raw = pick_sample(thr_dz_cur, TOP - thr_dz_cur);
    s.orient_x     = pick_sample(lo, hi);
    s.orient_y     = pick_sample(lo, hi);
    s.orient_z     = pick_sample(lo, hi);
    s.move_x_raw   = pick_sample(lo, hi);
    s.move_y_raw   = pick_sample(lo, hi);
    s.move_z_raw   = pick_sample(lo, hi);
    s.precision_on = 1'($urandom_range(0, 1));
    s.rocket_on    = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic sample_set_t set_of(int thr, int ox, int oy, int oz,
                                         int mx, int my, int mz, bit prec, bit rocket);
    sample_set_t s;
    s.throttle_raw = thr[SB-1:0];
    s.orient_x     = ox[SB-1:0];
    s.orient_y     = oy[SB-1:0];
    s.orient_z     = oz[SB-1:0];
    s.move_x_raw   = mx[SB-1:0];
    s.move_y_raw   = my[SB-1:0];
    s.move_z_raw   = mz[SB-1:0];
    s.precision_on = prec;
    s.rocket_on    = rocket;
    return s;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Write one register at a falling edge; the block takes it at the next rising edge.
  task automatic cfg_write(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_STICK_DZ:     stick_dz_cur     = int'(value[DZ_W-1:0]);
      CFG_THR_DZ:       thr_dz_cur       = int'(value[DZ_W-1:0]);
      CFG_NORMAL_FS:    fs_normal_cur    = int'(value[FS_W-1:0]);
      CFG_PRECISION_FS: fs_precision_cur = int'(value[FS_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic cfg_all(int unsigned sdz, int unsigned tdz, int unsigned nfs, int unsigned pfs);
    cfg_write(CFG_STICK_DZ, sdz);
    cfg_write(CFG_THR_DZ, tdz);
    cfg_write(CFG_NORMAL_FS, nfs);
    cfg_write(CFG_PRECISION_FS, pfs);
  endtask

  // Block until every queued item is taken and every expected result is checked.
  task automatic wait_drained();
    while (pending_sets_q.size() != 0 || items_taken != items_issued ||
           expected_controls_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_random(int n, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) pending_sets_q.push_back(rand_set());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued sample sets at falling edges, hold each until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && items_taken != items_issued) begin
      // hold the current item until the block accepts it
    end else if (src_gap > 0) begin
      in_if.valid <= 1'b0;
      src_gap--;
    end else if (pending_sets_q.size() != 0) begin
      sample_set_t s;
      s = pending_sets_q.pop_front();
      in_if.throttle_raw <= s.throttle_raw;
      in_if.orient_x     <= s.orient_x;
      in_if.orient_y     <= s.orient_y;
      in_if.orient_z     <= s.orient_z;
      in_if.move_x_raw   <= s.move_x_raw;
      in_if.move_y_raw   <= s.move_y_raw;
      in_if.move_z_raw   <= s.move_z_raw;
      in_if.precision_on <= s.precision_on;
      in_if.rocket_on    <= s.rocket_on;
      in_if.valid        <= 1'b1;
      items_issued++;
      // Leave a gap after this item now and then.
      if ($urandom_range(0, 99) < src_idle_pct) src_gap = gap_len();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Record each accepted item and predict its result with the current configuration.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      taken_set.throttle_raw = in_if.throttle_raw;
      taken_set.orient_x     = in_if.orient_x;
      taken_set.orient_y     = in_if.orient_y;
      taken_set.orient_z     = in_if.orient_z;
      taken_set.move_x_raw   = in_if.move_x_raw;
      taken_set.move_y_raw   = in_if.move_y_raw;
      taken_set.move_z_raw   = in_if.move_z_raw;
      taken_set.precision_on = in_if.precision_on;
      taken_set.rocket_on    = in_if.rocket_on;
      expected_controls_q.push_back(predict_controls(taken_set));
      items_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      // Start a long hold-off when the sequence asks for one; count it here.
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (snk_gap > 0) begin
        out_if.ready <= 1'b0;
        snk_gap--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < snk_idle_pct) snk_gap = gap_len();
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_controls_q.size() == 0) begin
        $error("result with no item outstanding: throttle_out %0d, yaw %0d",
               out_if.throttle_out, out_if.yaw);
        fail_cnt++;
      end else begin
        want = expected_controls_q.pop_front();
        check_field("throttle_out", 32'(want.throttle_out), 32'(out_if.throttle_out));
        check_field("steer",  32'(want.steer),  32'(out_if.steer));
        check_field("yaw",    32'(want.yaw),    32'(out_if.yaw));
        check_field("pitch",  32'(want.pitch),  32'(out_if.pitch));
        check_field("roll",   32'(want.roll),   32'(out_if.roll));
        check_field("move_x", 32'(want.move_x), 32'(out_if.move_x));
        check_field("move_y", 32'(want.move_y), 32'(out_if.move_y));
        check_field("move_z", 32'(want.move_z), 32'(out_if.move_z));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_STICK_DZ;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.throttle_raw = '0;
    in_if.orient_x     = '0;
    in_if.orient_y     = '0;
    in_if.orient_z     = '0;
    in_if.move_x_raw   = '0;
    in_if.move_y_raw   = '0;
    in_if.move_z_raw   = '0;
    in_if.precision_on = 1'b0;
    in_if.rocket_on    = 1'b0;
    out_if.ready       = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets at reset configuration (band 462..562, throttle margin 25).
    src_idle_pct = 20;
    snk_idle_pct = 20;
    pending_sets_q.push_back(set_of(512, 512, 512, 512, 512, 512, 512, 0, 0));
    pending_sets_q.push_back(set_of(0, 0, 0, 0, 0, 0, 0, 0, 1));
    pending_sets_q.push_back(set_of(TOP, TOP, TOP, TOP, TOP, TOP, TOP, 1, 0));
    pending_sets_q.push_back(set_of(TOP, TOP, 0, 512, TOP, 0, 512, 0, 1));
    pending_sets_q.push_back(set_of(1, 0, TOP, 1, 0, TOP, 1, 1, 1));
    // Band edges: first sample out of the band on each side, and the last one inside.
    pending_sets_q.push_back(set_of(25, 562, 462, 561, 463, 563, 461, 0, 0));
    pending_sets_q.push_back(set_of(998, 461, 563, 462, 562, 461, 563, 1, 1));
    pending_sets_q.push_back(set_of(24, 563, 461, 562, 461, 562, 462, 0, 1));
    pending_sets_q.push_back(set_of(999, 1022, 1, 1022, 1, 1022, 1, 1, 0));
    pending_sets_q.push_back(set_of(26, 700, 300, 900, 100, 600, 400, 0, 0));
    pending_sets_q.push_back(set_of(997, 300, 700, 100, 900, 400, 600, 1, 1));
    pending_sets_q.push_back(set_of(511, 513, 511, 900, 100, 700, 300, 1, 0));
    wait_drained();

    run_random(150, 30, 30);

    // Zero band and margin, smallest nonzero precision scale; no idling on either side.
    cfg_all(0, 0, FS_MAX, 1);
    pending_sets_q.push_back(set_of(0, 511, 512, 513, 511, 512, 513, 1, 0));
    pending_sets_q.push_back(set_of(TOP, 513, 511, 512, 513, 511, 512, 0, 1));
    run_random(100, 0, 0);

    // Widest band: high branch degenerates to full deflection; zero normal scale.
    cfg_all(511, 511, 0, FS_MAX);
    pending_sets_q.push_back(set_of(511, TOP, 1, 0, TOP, 1, 0, 1, 1));
    pending_sets_q.push_back(set_of(512, TOP, 1, 2, TOP, 1, 2, 0, 0));
    pending_sets_q.push_back(set_of(513, 1022, 2, TOP, 0, 1022, 512, 1, 0));
    run_random(80, 50, 50);

    // Near-widest band, smallest nonzero normal scale, zero precision scale.
    cfg_all(510, 510, 1, 0);
    run_random(80, 20, 40);

    // Random settings, varying the idling mix.
    repeat (4) begin
      cfg_all($urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, FS_MAX), $urandom_range(0, FS_MAX));
      run_random(80, $urandom_range(0, 60), $urandom_range(0, 60));
    end

    // Back-pressure: stall the receiver for a long stretch while the sender keeps
    // offering items back to back, so the pipe fills and the input stalls.
    cfg_all(32'(STICK_DZ_RST), 32'(THR_DZ_RST), 32'(NORMAL_FS_RST), 32'(PRECISION_FS_RST));
    hold_asked++;
    run_random(60, 0, 0);

    // Let any stray result show up before deciding.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[joystick_deadzone_axis_mapper.f]
design/jdam_pkg.sv
design/jdam_if.sv
design/jdam_div_stage.sv
design/jdam_stick_prep.sv
design/jdam_lane.sv
design/jdam_merge.sv
design/joystick_deadzone_axis_mapper.sv
design/jdam_chk.sv
bench/tb_joystick_deadzone_axis_mapper.sv
